>>> rtl/pet_pkg.sv
// Package for the polygon edge intersection test unit.
// Holds the request codes, the vertex and command types and the datapath widths.
// No dependencies.
package pet_pkg;

	localparam logic [2:0] FN_APP_A = 3'd0;
	localparam logic [2:0] FN_APP_B = 3'd1;
	localparam logic [2:0] FN_CLR_A = 3'd2;
	localparam logic [2:0] FN_CLR_B = 3'd3;
	localparam logic [2:0] FN_TEST  = 3'd4;

	localparam int COORD_W = 16;
	localparam int ABS_W   = 17;
	localparam int OFS_W   = 18;
	localparam int PD_W    = 34;
	localparam int PN_W    = 35;
	localparam int N_W     = 36;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} vtx_t;

	typedef struct packed {
		logic app_a;
		logic app_b;
		logic clr_a;
		logic clr_b;
		logic start;
		logic issue;
		logic load_res;
	} pet_cmd_t;

	function automatic logic signed [ABS_W-1:0] sx17(input logic [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic signed [OFS_W-1:0] sx18(input logic [ABS_W-1:0] v);
		return {v[ABS_W-1], v};
	endfunction

endpackage

>>> rtl/pet_dp.sv
// Datapath of the polygon edge intersection test unit: vertex stores, counts,
// drop flag and the pipelined segment crossing test.
// Depends on pet_pkg.
module pet_dp import pet_pkg::*; #(
	parameter int MAX_VERTS = 16,
	localparam int IW = $clog2(MAX_VERTS),
	localparam int CW = $clog2(MAX_VERTS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pet_cmd_t                  cmd,
	input  logic [IW-1:0]             ia,
	input  logic [IW-1:0]             ia2,
	input  logic [IW-1:0]             ib,
	input  logic [IW-1:0]             ib2,
	input  logic signed [COORD_W-1:0] vert_x,
	input  logic signed [COORD_W-1:0] vert_y,
	input  logic signed [COORD_W-1:0] a_pos_x,
	input  logic signed [COORD_W-1:0] a_pos_y,
	input  logic signed [COORD_W-1:0] b_pos_x,
	input  logic signed [COORD_W-1:0] b_pos_y,
	output logic [CW-1:0]             a_cnt,
	output logic [CW-1:0]             b_cnt,
	output logic                      busy,
	output logic                      hit,
	output logic                      dropped
);

	vtx_t a_mem [MAX_VERTS];
	vtx_t b_mem [MAX_VERTS];

	logic [CW-1:0] a_cnt_q, b_cnt_q;
	logic          drop_q, drop_cap_q, acc_q;
	logic          res_hit_q, res_drop_q;
	logic          a_full, b_full, seg_hit;

	logic [COORD_W-1:0] apx_q, apy_q, bpx_q, bpy_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	vtx_t a1_s1, a2_s1, b1_s1, b2_s1;

	logic signed [ABS_W-1:0] p1x_s2, p1y_s2, p3x_s2, p3y_s2;
	logic signed [ABS_W-1:0] dxa_s2, dya_s2, dxb_s2, dyb_s2;

	logic signed [OFS_W-1:0] ox_s3, oy_s3;
	logic signed [ABS_W-1:0] dxa_s3, dya_s3, dxb_s3, dyb_s3;

	logic signed [PD_W-1:0] pd1_s4, pd2_s4;
	logic signed [PN_W-1:0] pa1_s4, pa2_s4, pb1_s4, pb2_s4;

	logic signed [N_W-1:0] den_s5, na_s5, nb_s5;

	assign a_full = (a_cnt_q == CW'(MAX_VERTS));
	assign b_full = (b_cnt_q == CW'(MAX_VERTS));

	// Vertex stores: one write port, two registered read ports each.
	always_ff @(posedge clk) begin
		if (cmd.app_a && !a_full) begin
			a_mem[a_cnt_q[IW-1:0]] <= '{x: vert_x, y: vert_y};
		end
		if (cmd.app_b && !b_full) begin
			b_mem[b_cnt_q[IW-1:0]] <= '{x: vert_x, y: vert_y};
		end
		a1_s1 <= a_mem[ia];
		a2_s1 <= a_mem[ia2];
		b1_s1 <= b_mem[ib];
		b2_s1 <= b_mem[ib2];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			apx_q <= a_pos_x;
			apy_q <= a_pos_y;
			bpx_q <= b_pos_x;
			bpy_q <= b_pos_y;
		end
		p1x_s2 <= sx17(a1_s1.x) + sx17(apx_q);
		p1y_s2 <= sx17(a1_s1.y) + sx17(apy_q);
		p3x_s2 <= sx17(b1_s1.x) + sx17(bpx_q);
		p3y_s2 <= sx17(b1_s1.y) + sx17(bpy_q);
		dxa_s2 <= sx17(a2_s1.x) - sx17(a1_s1.x);
		dya_s2 <= sx17(a2_s1.y) - sx17(a1_s1.y);
		dxb_s2 <= sx17(b2_s1.x) - sx17(b1_s1.x);
		dyb_s2 <= sx17(b2_s1.y) - sx17(b1_s1.y);

		ox_s3  <= sx18(p1x_s2) - sx18(p3x_s2);
		oy_s3  <= sx18(p1y_s2) - sx18(p3y_s2);
		dxa_s3 <= dxa_s2;
		dya_s3 <= dya_s2;
		dxb_s3 <= dxb_s2;
		dyb_s3 <= dyb_s2;

		pd1_s4 <= PD_W'(dyb_s3) * PD_W'(dxa_s3);
		pd2_s4 <= PD_W'(dxb_s3) * PD_W'(dya_s3);
		pa1_s4 <= PN_W'(dxb_s3) * PN_W'(oy_s3);
		pa2_s4 <= PN_W'(dyb_s3) * PN_W'(ox_s3);
		pb1_s4 <= PN_W'(dxa_s3) * PN_W'(oy_s3);
		pb2_s4 <= PN_W'(dya_s3) * PN_W'(ox_s3);

		den_s5 <= N_W'(pd1_s4) - N_W'(pd2_s4);
		na_s5  <= N_W'(pa1_s4) - N_W'(pa2_s4);
		nb_s5  <= N_W'(pb1_s4) - N_W'(pb2_s4);

		if (cmd.load_res) begin
			res_hit_q  <= acc_q;
			res_drop_q <= drop_cap_q;
		end
	end

	// Both parameters lie in [0,1] when each numerator sits between zero and
	// the denominator on the denominator's side of zero.
	always_comb begin
		seg_hit = 1'b0;
		if (den_s5 > 0) begin
			seg_hit = (na_s5 >= 0) && (na_s5 <= den_s5) && (nb_s5 >= 0) && (nb_s5 <= den_s5);
		end else if (den_s5 < 0) begin
			seg_hit = (na_s5 <= 0) && (na_s5 >= den_s5) && (nb_s5 <= 0) && (nb_s5 >= den_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q    <= '0;
			b_cnt_q    <= '0;
			drop_q     <= 1'b0;
			drop_cap_q <= 1'b0;
			acc_q      <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
		end else begin
			if (cmd.app_a) begin
				if (a_full) begin
					drop_q <= 1'b1;
				end else begin
					a_cnt_q <= a_cnt_q + CW'(1);
				end
			end
			if (cmd.app_b) begin
				if (b_full) begin
					drop_q <= 1'b1;
				end else begin
					b_cnt_q <= b_cnt_q + CW'(1);
				end
			end
			if (cmd.clr_a) begin
				a_cnt_q <= '0;
				drop_q  <= 1'b0;
			end
			if (cmd.clr_b) begin
				b_cnt_q <= '0;
				drop_q  <= 1'b0;
			end
			if (cmd.start) begin
				drop_cap_q <= drop_q;
				acc_q      <= 1'b0;
			end else if (v_s5 && seg_hit) begin
				acc_q <= 1'b1;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign a_cnt   = a_cnt_q;
	assign b_cnt   = b_cnt_q;
	assign busy    = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign hit     = res_hit_q;
	assign dropped = res_drop_q;

endmodule

>>> rtl/pet_ctrl.sv
// Controller of the polygon edge intersection test unit: request decode, the
// walk over all edge pairs and the response register handshake.
// Depends on pet_pkg.
module pet_ctrl import pet_pkg::*; #(
	parameter int MAX_VERTS = 16,
	localparam int IW = $clog2(MAX_VERTS),
	localparam int CW = $clog2(MAX_VERTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [2:0]    func,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  logic [CW-1:0] a_cnt,
	input  logic [CW-1:0] b_cnt,
	input  logic          busy,
	output pet_cmd_t      cmd,
	output logic [IW-1:0] ia,
	output logic [IW-1:0] ia2,
	output logic [IW-1:0] ib,
	output logic [IW-1:0] ib2
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_t;

	state_t        state_q;
	logic [IW-1:0] i_q, j_q, i_nxt, j_nxt;
	logic          rsp_valid_q, acc, last_i, last_j;

	assign acc    = req_valid && req_ready;
	assign i_nxt  = i_q + IW'(1);
	assign j_nxt  = j_q + IW'(1);
	assign last_i = ((CW'(i_q) + CW'(1)) == a_cnt);
	assign last_j = ((CW'(j_q) + CW'(1)) == b_cnt);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign ia  = i_q;
	assign ia2 = last_i ? '0 : i_nxt;
	assign ib  = j_q;
	assign ib2 = last_j ? '0 : j_nxt;

	always_comb begin
		cmd          = '0;
		cmd.app_a    = acc && (func == FN_APP_A);
		cmd.app_b    = acc && (func == FN_APP_B);
		cmd.clr_a    = acc && (func == FN_CLR_A);
		cmd.clr_b    = acc && (func == FN_CLR_B);
		cmd.start    = acc && (func == FN_TEST);
		cmd.issue    = (state_q == ST_WALK);
		cmd.load_res = (state_q == ST_DRAIN) && !busy && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						i_q <= '0;
						j_q <= '0;
						if (a_cnt == '0 || b_cnt == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_nxt;
						end
					end else begin
						j_q <= j_nxt;
					end
				end
				ST_DRAIN: begin
					if (cmd.load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/polygon_edge_intersection_test_unit.sv
// Top level of the polygon edge intersection test unit.
// Joins the controller pet_ctrl and the datapath pet_dp; depends on pet_pkg.
//
// Channel   Handshake                Payload
// request   req_valid / req_ready    func, vert_x, vert_y, a_pos_x, a_pos_y, b_pos_x, b_pos_y
// response  rsp_valid / rsp_ready    hit, dropped
//
// Append, clear and unknown requests give no response.
// A test walks one edge pair per cycle from the vertex stores through the pipelined
// datapath; rsp_valid rises once the pipeline has drained and the result is loaded.
// The response register lets new requests in while a response waits; a test
// that finishes while the previous response is still held waits for it.
// Reset empties both polygons and clears the drop flag; no clearing pass is needed.
module polygon_edge_intersection_test_unit import pet_pkg::*; #(
	parameter int MAX_VERTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [2:0]                func,
	input  logic signed [COORD_W-1:0] vert_x,
	input  logic signed [COORD_W-1:0] vert_y,
	input  logic signed [COORD_W-1:0] a_pos_x,
	input  logic signed [COORD_W-1:0] a_pos_y,
	input  logic signed [COORD_W-1:0] b_pos_x,
	input  logic signed [COORD_W-1:0] b_pos_y,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      hit,
	output logic                      dropped
);

	localparam int IW = $clog2(MAX_VERTS);
	localparam int CW = $clog2(MAX_VERTS + 1);

	pet_cmd_t      cmd;
	logic [IW-1:0] ia, ia2, ib, ib2;
	logic [CW-1:0] a_cnt, b_cnt;
	logic          busy;

	pet_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.a_cnt     (a_cnt),
		.b_cnt     (b_cnt),
		.busy      (busy),
		.cmd       (cmd),
		.ia        (ia),
		.ia2       (ia2),
		.ib        (ib),
		.ib2       (ib2)
	);

	pet_dp #(.MAX_VERTS(MAX_VERTS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.ia      (ia),
		.ia2     (ia2),
		.ib      (ib),
		.ib2     (ib2),
		.vert_x  (vert_x),
		.vert_y  (vert_y),
		.a_pos_x (a_pos_x),
		.a_pos_y (a_pos_y),
		.b_pos_x (b_pos_x),
		.b_pos_y (b_pos_y),
		.a_cnt   (a_cnt),
		.b_cnt   (b_cnt),
		.busy    (busy),
		.hit     (hit),
		.dropped (dropped)
	);

endmodule
